/* rtl/rgb_to_hsv_converter_assert.svh */
// Assertion macros for the RGB to HSV converter.
// Included by the top level; no other dependencies.
`ifndef RGB_TO_HSV_CONVERTER_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication check
`define RTH_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgb_to_hsv_converter: same-cycle check failed");

// Next-cycle implication check
`define RTH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgb_to_hsv_converter: next-cycle check failed");

`else

`define RTH_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define RTH_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* rtl/rth_pkg.sv */
// Shared types and constants for the RGB to HSV converter.
// No dependencies; used by the front stage, divider stages and top level.
package rth_pkg;

   // Channel and result widths
   localparam int CHAN_W = 8;
   localparam int HUE_W  = 16;
   localparam int DIV_W  = 11;   // holds 6 * (max - min), up to 1530

   // Division is spread over this many register stages
   localparam int DIV_STAGES          = 4;
   localparam int HUE_STEPS_PER_STAGE = HUE_W / DIV_STAGES;
   localparam int SAT_STEPS_PER_STAGE = CHAN_W / DIV_STAGES;

   // Payload carried down the pipeline
   typedef struct packed {
      logic [DIV_W-1:0]  six_d;     // hue divisor
      logic [DIV_W-1:0]  hue_rem;   // hue partial remainder, below six_d
      logic [HUE_W-1:0]  hue_q;     // hue quotient, grows MSB first
      logic [CHAN_W-1:0] mx;        // largest channel, also the sat divisor
      logic [CHAN_W-1:0] sat_rem;   // sat partial remainder, below mx
      logic [CHAN_W-1:0] sat_low;   // sat dividend bits still to shift in
      logic [CHAN_W-1:0] sat_q;     // sat quotient, grows MSB first
      logic              gray;      // all channels equal
      logic [CHAN_W-1:0] alpha;
   } rth_work_type;

endpackage

/* rtl/rth_front.sv */
// First pipeline stage: max/min, sector numerator and divider setup.
// Depends on rth_pkg.
module rth_front (
   input  logic                      clock,
   input  logic                      load,
   input  logic [rth_pkg::CHAN_W-1:0] red,
   input  logic [rth_pkg::CHAN_W-1:0] green,
   input  logic [rth_pkg::CHAN_W-1:0] blue,
   input  logic [rth_pkg::CHAN_W-1:0] alpha,
   output rth_pkg::rth_work_type      work_ff
);
   import rth_pkg::*;

   logic [CHAN_W-1:0]   mx;
   logic [CHAN_W-1:0]   mn;
   logic [CHAN_W-1:0]   d;
   logic [DIV_W-1:0]    six_d;
   logic [DIV_W:0]      n_raw;
   logic [DIV_W:0]      n_fix;
   logic [2*CHAN_W-1:0] sat_num;
   rth_work_type        work_in;

   // Largest and smallest channel
   always_comb begin
      mx = (red >= green) ? ((red >= blue) ? red : blue)
                          : ((green >= blue) ? green : blue);
      mn = (red <= green) ? ((red <= blue) ? red : blue)
                          : ((green <= blue) ? green : blue);
      d     = mx - mn;
      six_d = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};
   end

   // Sector numerator, priority red, green, blue; red wraps by one turn
   always_comb begin
      if (red == mx) begin
         n_raw = {4'b0, green} - {4'b0, blue};
      end else if (green == mx) begin
         n_raw = {3'b0, d, 1'b0} + {4'b0, blue} - {4'b0, red};
      end else begin
         n_raw = {2'b0, d, 2'b00} + {4'b0, red} - {4'b0, green};
      end
      n_fix = n_raw[DIV_W] ? (n_raw + {1'b0, six_d}) : n_raw;
   end

   // d * 255 as (d << 8) - d; its upper byte is already below mx
   assign sat_num = {d, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, d};

   always_comb begin
      work_in.six_d   = six_d;
      work_in.hue_rem = n_fix[DIV_W-1:0];
      work_in.hue_q   = '0;
      work_in.mx      = mx;
      work_in.sat_rem = sat_num[2*CHAN_W-1:CHAN_W];
      work_in.sat_low = sat_num[CHAN_W-1:0];
      work_in.sat_q   = '0;
      work_in.gray    = (d == '0);
      work_in.alpha   = alpha;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         work_ff <= work_in;
      end
   end

endmodule

/* rtl/rth_div_stage.sv */
// One stage of the two restoring dividers (hue and saturation).
// Depends on rth_pkg.
module rth_div_stage (
   input  logic                 clock,
   input  logic                 load,
   input  rth_pkg::rth_work_type work_in_d,
   output rth_pkg::rth_work_type work_ff
);
   import rth_pkg::*;

   rth_work_type   work_in;
   logic [DIV_W:0] hue_trial;
   logic [CHAN_W:0] sat_trial;

   always_comb begin
      work_in   = work_in_d;
      hue_trial = '0;
      sat_trial = '0;
      // Hue: a few quotient bits per stage
      for (int i = 0; i < HUE_STEPS_PER_STAGE; i++) begin
         hue_trial = {work_in.hue_rem, 1'b0};
         if (hue_trial >= {1'b0, work_in.six_d}) begin
            hue_trial     = hue_trial - {1'b0, work_in.six_d};
            work_in.hue_q = {work_in.hue_q[HUE_W-2:0], 1'b1};
         end else begin
            work_in.hue_q = {work_in.hue_q[HUE_W-2:0], 1'b0};
         end
         work_in.hue_rem = hue_trial[DIV_W-1:0];
      end
      // Saturation: shift in the low dividend bits
      for (int j = 0; j < SAT_STEPS_PER_STAGE; j++) begin
         sat_trial = {work_in.sat_rem, work_in.sat_low[CHAN_W-1]};
         work_in.sat_low = {work_in.sat_low[CHAN_W-2:0], 1'b0};
         if (sat_trial >= {1'b0, work_in.mx}) begin
            sat_trial     = sat_trial - {1'b0, work_in.mx};
            work_in.sat_q = {work_in.sat_q[CHAN_W-2:0], 1'b1};
         end else begin
            work_in.sat_q = {work_in.sat_q[CHAN_W-2:0], 1'b0};
         end
         work_in.sat_rem = sat_trial[CHAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         work_ff <= work_in;
      end
   end

endmodule

/* rtl/rgb_to_hsv_converter.sv */
// RGB to HSV pixel converter, top level.
// Depends on rth_pkg, rth_front, rth_div_stage and rgb_to_hsv_converter_assert.svh.
//
// Usage:
//   req_* carries one RGBA pixel per beat; rsp_* returns hue, saturation,
//   value and the unchanged alpha for each pixel, in order, one beat each.
//   Hue is a fraction of a turn in 1/65536 units; gray pixels give hue and
//   saturation of zero.
// Path: the edge that accepts a beat loads it into the setup stage; it then
//   passes through the four divider stages in order and is presented on
//   rsp_tvalid from the last of them, holding wherever a stall stops it.
// Throughput: one pixel per clock without stalls. The two restoring
//   dividers (16 hue quotient bits, 8 saturation bits) are split into four
//   bits and two bits per stage, so each stage can take a new pixel each cycle.
// Reset: clears all stage valid bits; the pipeline comes out empty and
//   ready for input in the first cycle after reset.
// Stall: when rsp_tready is low the result beat holds; each stage still
//   loads while it or some stage below it is empty, so bubbles close up and
//   req_tready falls only when all five stages hold pixels.
module rgb_to_hsv_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // red, green, blue, alpha (8 bits each)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // hue (16), saturation, value, alpha_out (8 each)
);
   import rth_pkg::*;

   `include "rgb_to_hsv_converter_assert.svh"

   rth_work_type            stage_q [DIV_STAGES+1];
   logic [DIV_STAGES:0]     valid_ff;
   logic [DIV_STAGES:0]     valid_in;
   logic [DIV_STAGES:0]     valid_up;
   logic [DIV_STAGES:0]     load;
   logic [HUE_W-1:0]        hue;
   logic [CHAN_W-1:0]       saturation;

   // Per-stage load: a stage takes the beat above it when empty or moving on
   always_comb begin
      load[DIV_STAGES] = !valid_ff[DIV_STAGES] || rsp_tready;
      for (int i = DIV_STAGES - 1; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
   end

   assign valid_up   = {valid_ff[DIV_STAGES-1:0], req_tvalid};
   assign valid_in   = (load & valid_up) | (~load & valid_ff);
   assign req_tready = load[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Setup stage
   rth_front u_front (
      .clock   (clock),
      .load    (load[0] & req_tvalid),
      .red     (req_tdata[7:0]),
      .green   (req_tdata[15:8]),
      .blue    (req_tdata[23:16]),
      .alpha   (req_tdata[31:24]),
      .work_ff (stage_q[0])
   );

   // Divider stages
   for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
      rth_div_stage u_div (
         .clock     (clock),
         .load      (load[g] & valid_ff[g-1]),
         .work_in_d (stage_q[g-1]),
         .work_ff   (stage_q[g])
      );
   end

   // Result beat; gray pixels force hue and saturation to zero
   assign hue        = stage_q[DIV_STAGES].gray ? '0 : stage_q[DIV_STAGES].hue_q;
   assign saturation = stage_q[DIV_STAGES].gray ? '0 : stage_q[DIV_STAGES].sat_q;
   assign rsp_tvalid = valid_ff[DIV_STAGES];
   assign rsp_tdata  = {stage_q[DIV_STAGES].alpha, stage_q[DIV_STAGES].mx,
                        saturation, hue};

   // Checks
   `RTH_ASSERT_SAME(a_sat_zero_gray, clock, reset,
      rsp_tvalid && (rsp_tdata[23:16] == 8'd0), rsp_tdata[15:0] == 16'd0)
   `RTH_ASSERT_SAME(a_black_no_sat, clock, reset,
      rsp_tvalid && (rsp_tdata[31:24] == 8'd0), rsp_tdata[23:16] == 8'd0)
   `RTH_ASSERT_SAME(a_full_blocks_input, clock, reset,
      (&valid_ff) && !rsp_tready, !req_tready)
   `RTH_ASSERT_NEXT(a_accept_fills_setup, clock, reset,
      req_tvalid && req_tready, valid_ff[0])

endmodule

/* sim/hsv_result_checker.sv */
// Result checker for the RGB to HSV converter: watches both stream channels,
// predicts each pixel's hue, saturation and value, and compares in order.
// Depends only on the converter's port layout.
`timescale 1ns / 1ps

module hsv_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // red, green, blue, alpha (8 bits each)
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // hue (16), saturation, value, alpha_out (8 each)
   output int          mismatch_count,
   output int          pending_count,
   output int          checked_count
);

   typedef struct packed {
      logic [15:0] hue;
      logic [7:0]  saturation;
      logic [7:0]  value;
      logic [7:0]  alpha_out;
   } hsv_pixel_type;

   hsv_pixel_type expected_hsv[$];

   // Integer sextant hue, truncated saturation, max channel as value
   function automatic hsv_pixel_type predict_hsv(input logic [31:0] rgba);
      int            r, g, b, mx, mn, d, n;
      longint        scaled;
      hsv_pixel_type px;
      r = rgba[7:0];
      g = rgba[15:8];
      b = rgba[23:16];
      mx = (r > g) ? r : g;
      mx = (mx > b) ? mx : b;
      mn = (r < g) ? r : g;
      mn = (mn < b) ? mn : b;
      d = mx - mn;
      px.hue        = '0;
      px.saturation = '0;
      px.value      = mx[7:0];
      px.alpha_out  = rgba[31:24];
      if (d != 0) begin
         px.saturation = 8'((d * 255) / mx);
         // sector priority: red, then green, then blue
         if (r == mx)
            n = g - b;
         else if (g == mx)
            n = 2 * d + b - r;
         else
            n = 4 * d + r - g;
         if (n < 0)
            n += 6 * d;
         scaled = (longint'(n) * 65536) / (6 * d);
         px.hue = scaled[15:0];
      end
      return px;
   endfunction

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      checked_count  = 0;
   end

   // Push a prediction per accepted input beat, compare per accepted result beat
   always @(posedge clock) begin
      hsv_pixel_type want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_hsv.push_back(predict_hsv(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_hsv.size() == 0) begin
               $error("result beat with no pixel outstanding: tdata=%h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_hsv.pop_front();
               checked_count++;
               if (rsp_tdata[15:0] !== want.hue) begin
                  $error("hue: expected %0d, got %0d", want.hue, rsp_tdata[15:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[23:16] !== want.saturation) begin
                  $error("saturation: expected %0d, got %0d",
                         want.saturation, rsp_tdata[23:16]);
                  mismatch_count++;
               end
               if (rsp_tdata[31:24] !== want.value) begin
                  $error("value: expected %0d, got %0d", want.value, rsp_tdata[31:24]);
                  mismatch_count++;
               end
               if (rsp_tdata[39:32] !== want.alpha_out) begin
                  $error("alpha_out: expected %0d, got %0d",
                         want.alpha_out, rsp_tdata[39:32]);
                  mismatch_count++;
               end
            end
         end
         pending_count <= expected_hsv.size();
      end
   end

endmodule

/* sim/rgb_to_hsv_converter_test.sv */
// Top of the RGB to HSV converter testbench: clock, reset, pixel stimulus,
// receiver back-pressure and the verdict. Depends on rgb_to_hsv_converter
// and hsv_result_checker.
`timescale 1ns / 1ps

module rgb_to_hsv_converter_test;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;

   int mismatch_count;
   int pending_count;
   int checked_count;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_asks      = 0;   // bumped by stimulus to request a long receiver hold-off
   int pixels_sent    = 0;

   rgb_to_hsv_converter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   hsv_result_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   // 8 ns clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("timeout: %0d pixels sent, %0d results checked", pixels_sent, checked_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Receiver: random stalls, plus a counted hold-off when requested
   initial begin
      int hold_seen;
      int hold_left;
      hold_seen  = 0;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = 80;
         end
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else begin
            rsp_tready = ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Offer one pixel beat, with random idle cycles ahead of it; returns at the
   // falling edge after acceptance with tvalid still high
   task automatic send_pixel(input logic [31:0] rgba);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = rgba;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic send_rgba(input logic [7:0] r, g, b, a);
      send_pixel({a, b, g, r});
   endtask

   // Drop tvalid and wait until every pixel in flight has come back
   task automatic drain;
      req_tvalid = 1'b0;
      wait (pending_count == 0);
      @(negedge clock);
   endtask

   // Random pixel, biased toward gray and tied channels now and then
   function automatic logic [31:0] random_pixel();
      logic [7:0] r, g, b, a;
      int         shape;
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      a = 8'($urandom);
      shape = $urandom_range(0, 9);
      case (shape)
         0: begin
            g = r;
            b = r;
         end
         1: g = r;
         2: b = g;
         3: b = r;
         default: ;
      endcase
      return {a, b, g, r};
   endfunction

   initial begin
      req_tvalid = 1'b0;
      req_tdata  = '0;
      reset      = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: gray and black, primaries, tied maxima, channel extremes
      send_rgba(8'd0,   8'd0,   8'd0,   8'd0);     // black
      send_rgba(8'd255, 8'd255, 8'd255, 8'd255);   // white
      send_rgba(8'd128, 8'd128, 8'd128, 8'hA5);    // mid gray
      send_rgba(8'd1,   8'd1,   8'd1,   8'h5A);
      send_rgba(8'd255, 8'd0,   8'd0,   8'd255);   // red
      send_rgba(8'd0,   8'd255, 8'd0,   8'd0);     // green
      send_rgba(8'd0,   8'd0,   8'd255, 8'd128);   // blue
      send_rgba(8'd255, 8'd255, 8'd0,   8'd1);     // red/green tie
      send_rgba(8'd0,   8'd255, 8'd255, 8'd2);     // green/blue tie
      send_rgba(8'd255, 8'd0,   8'd255, 8'd3);     // red/blue tie
      send_rgba(8'd255, 8'd0,   8'd1,   8'd4);     // red sector, hue just under a turn
      send_rgba(8'd255, 8'd1,   8'd0,   8'd5);
      send_rgba(8'd1,   8'd0,   8'd0,   8'd6);     // smallest nonzero spread
      send_rgba(8'd0,   8'd1,   8'd0,   8'd7);
      send_rgba(8'd0,   8'd0,   8'd1,   8'd8);
      send_rgba(8'd255, 8'd254, 8'd254, 8'd9);
      send_rgba(8'd254, 8'd255, 8'd255, 8'd10);
      send_rgba(8'd0,   8'd1,   8'd255, 8'd11);
      send_rgba(8'd1,   8'd255, 8'd0,   8'd12);
      send_rgba(8'd170, 8'd85,  8'd255, 8'hF0);
      send_rgba(8'd85,  8'd170, 8'd15,  8'h0F);
      drain();

      // Random: four idle/stall phases
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 55;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 55;
            end
            default: begin
               send_idle_pct  = 19;
               recv_stall_pct = 19;
            end
         endcase
         for (int i = 0; i < 450; i++) begin
            // long receiver hold-off while the sender keeps offering
            if ((phase == 0 || phase == 3) && i == 100)
               hold_asks++;
            // sender pause until the pipeline has emptied
            if (phase == 2 && i == 200)
               drain();
            send_pixel(random_pixel());
         end
         drain();
      end

      repeat (20) @(posedge clock);
      $display("Converted %0d pixels (%0d results checked): gray, tied and extreme channels,",
               pixels_sent, checked_count);
      $display("random RGBA under sender gaps, receiver stalls and a full-pipeline hold-off.");
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
